/* rtl/osf_pkg.sv */
// Shared types and constants for the overlap suppression filter.
package osf_pkg;

   localparam int MAX_KEPT   = 64;
   localparam int COORD_BITS = 12;
   localparam int RATIO_BITS = 8;
   localparam int AREA_BITS  = 2 * COORD_BITS;
   localparam int PROD_BITS  = AREA_BITS + RATIO_BITS;
   localparam int CNT_BITS   = $clog2(MAX_KEPT + 1);
   localparam int IDX_BITS   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RATIO_NUM = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RATIO_DEN = 1'd1;

   localparam logic [RATIO_BITS-1:0] RATIO_NUM_RESET = 8'd2;
   localparam logic [RATIO_BITS-1:0] RATIO_DEN_RESET = 8'd5;

   typedef struct packed {
      logic [COORD_BITS-1:0] rect_x;
      logic [COORD_BITS-1:0] rect_y;
      logic [COORD_BITS-1:0] rect_width;
      logic [COORD_BITS-1:0] rect_height;
   } rect_type;

   localparam int RECT_BITS = $bits(rect_type);

   typedef struct packed {
      logic [COORD_BITS-1:0] rect_x;
      logic [COORD_BITS-1:0] rect_y;
      logic [COORD_BITS-1:0] rect_width;
      logic [COORD_BITS-1:0] rect_height;
      logic                  first_of_set;
   } req_type;

   typedef struct packed {
      logic keep;
      logic store_full;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } cmp_status_type;

endpackage

/* rtl/osf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module osf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/osf_cmp.sv */
// Shared compare pipeline: tests the new rectangle against one kept rectangle per cycle.
module osf_cmp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  osf_pkg::rect_type                cand,
   input  osf_pkg::rect_type                kept,
   input  logic [osf_pkg::RATIO_BITS-1:0]   ratio_den,
   input  logic [osf_pkg::PROD_BITS-1:0]    num_ref,
   output osf_pkg::cmp_status_type          status
);

   localparam int CB = osf_pkg::COORD_BITS;

   logic [CB:0]   ax1, bx1, ay1, by1, hix, hiy, difx, dify;
   logic [CB-1:0] lox, loy, ox, oy;
   logic          half_hit;

   logic                          a_valid_ff;
   logic [CB-1:0]                 ox_ff, oy_ff;
   logic                          a_half_ff;
   logic                          b_valid_ff;
   logic [osf_pkg::AREA_BITS-1:0] area_ff;
   logic                          b_half_ff;
   logic [osf_pkg::PROD_BITS-1:0] lhs;

   // span overlap: min of right edges minus max of left edges, floored at zero
   always_comb begin
      ax1  = {1'b0, cand.rect_x} + {1'b0, cand.rect_width};
      bx1  = {1'b0, kept.rect_x} + {1'b0, kept.rect_width};
      ay1  = {1'b0, cand.rect_y} + {1'b0, cand.rect_height};
      by1  = {1'b0, kept.rect_y} + {1'b0, kept.rect_height};
      lox  = (cand.rect_x > kept.rect_x) ? cand.rect_x : kept.rect_x;
      loy  = (cand.rect_y > kept.rect_y) ? cand.rect_y : kept.rect_y;
      hix  = (ax1 < bx1) ? ax1 : bx1;
      hiy  = (ay1 < by1) ? ay1 : by1;
      difx = hix - {1'b0, lox};
      dify = hiy - {1'b0, loy};
      // overlap never exceeds the candidate size, so it fits the coordinate width
      ox   = (hix > {1'b0, lox}) ? difx[CB-1:0] : '0;
      oy   = (hiy > {1'b0, loy}) ? dify[CB-1:0] : '0;
      half_hit = (ox > {1'b0, cand.rect_width[CB-1:1]}) &&
                 (oy > {1'b0, cand.rect_height[CB-1:1]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
      ox_ff     <= ox;
      oy_ff     <= oy;
      a_half_ff <= half_hit;
      area_ff   <= osf_pkg::AREA_BITS'(ox_ff) * osf_pkg::AREA_BITS'(oy_ff);
      b_half_ff <= a_half_ff;
   end

   assign lhs = osf_pkg::PROD_BITS'(area_ff) * osf_pkg::PROD_BITS'(ratio_den);

   assign status.busy = a_valid_ff | b_valid_ff;
   assign status.hit  = b_valid_ff && (b_half_ff || (lhs > num_ref));

endmodule

/* rtl/overlap_suppression_filter.sv */
// Top level of the overlap suppression filter: sequencer, kept-list RAM and ratio registers.
// Each rectangle beat goes through a setup step, then a scan in which the kept list is read
// out of the RAM one entry per cycle into a single compare pipeline, then drain and decide
// steps. The block accepts one rectangle at a time; a result waiting in the output register
// does not block acceptance of the next rectangle, though that rectangle's decide step waits
// for the register to empty. No clearing pass is needed.
module overlap_suppression_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  osf_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output osf_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [osf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [osf_pkg::RATIO_BITS-1:0]      csr_wr_data
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SETUP  = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_DECIDE = 2'd3;

   localparam logic [osf_pkg::CNT_BITS-1:0] MAX_CNT = osf_pkg::CNT_BITS'(osf_pkg::MAX_KEPT);

   logic [1:0]                       state_ff, state_in;
   logic [osf_pkg::RATIO_BITS-1:0]   num_ff, den_ff;
   logic [osf_pkg::AREA_BITS-1:0]    ref_ff, ref_in;
   logic [osf_pkg::PROD_BITS-1:0]    num_ref_ff;
   logic [osf_pkg::CNT_BITS-1:0]     count_ff, count_in;
   logic [osf_pkg::CNT_BITS-1:0]     issue_ff, issue_in;
   logic                             rd_valid_ff;
   logic                             sup_ff, sup_in;
   osf_pkg::rect_type                cand_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   osf_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                             accept, issue, produce, keep, full, wr_en;
   osf_pkg::rect_type                kept_rd;
   logic [osf_pkg::RECT_BITS-1:0]    kept_rd_bits;
   osf_pkg::cmp_status_type          cmp_status;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (state_ff == S_SCAN) && (issue_ff < count_ff);
   assign produce   = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_ready);
   assign keep      = !sup_ff;
   assign full      = keep && (count_ff >= MAX_CNT);
   assign wr_en     = produce && keep && !full;

   always_comb begin
      state_in     = state_ff;
      ref_in       = ref_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      sup_in       = sup_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sup_in   = 1'b0;
               issue_in = '0;
               state_in = S_SETUP;
               if (req_data.first_of_set) begin
                  count_in = '0;
                  ref_in   = osf_pkg::AREA_BITS'(req_data.rect_width) *
                             osf_pkg::AREA_BITS'(req_data.rect_height);
               end
            end
         end
         S_SETUP: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (issue) begin
               issue_in = issue_ff + 1'b1;
            end
            if (cmp_status.hit) begin
               sup_in = 1'b1;
            end
            if (!issue && !rd_valid_ff && !cmp_status.busy) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (produce) begin
               rsp_valid_in     = 1'b1;
               rsp_in.keep       = keep;
               rsp_in.store_full = full;
               if (wr_en) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         num_ff       <= osf_pkg::RATIO_NUM_RESET;
         den_ff       <= osf_pkg::RATIO_DEN_RESET;
         ref_ff       <= '0;
         count_ff     <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         sup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_ff       <= ref_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= issue;
         sup_ff       <= sup_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               osf_pkg::CSR_RATIO_NUM: num_ff <= csr_wr_data;
               osf_pkg::CSR_RATIO_DEN: den_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
      rsp_ff <= rsp_in;
      // limit product is registered every cycle, the cycle after the reference latches
      num_ref_ff <= osf_pkg::PROD_BITS'(num_ff) * osf_pkg::PROD_BITS'(ref_ff);
      if (accept) begin
         cand_ff.rect_x      <= req_data.rect_x;
         cand_ff.rect_y      <= req_data.rect_y;
         cand_ff.rect_width  <= req_data.rect_width;
         cand_ff.rect_height <= req_data.rect_height;
      end
   end

   osf_ram #(
      .WIDTH (osf_pkg::RECT_BITS),
      .DEPTH (osf_pkg::MAX_KEPT)
   ) u_kept_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[osf_pkg::IDX_BITS-1:0]),
      .wr_data (cand_ff),
      .rd_addr (issue_ff[osf_pkg::IDX_BITS-1:0]),
      .rd_data (kept_rd_bits)
   );

   assign kept_rd = kept_rd_bits;

   osf_cmp u_cmp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .cand      (cand_ff),
      .kept      (kept_rd),
      .ratio_den (den_ff),
      .num_ref   (num_ref_ff),
      .status    (cmp_status)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // store_full is only ever reported on a kept rectangle
   a_full_implies_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.store_full || rsp_data.keep))
      else $error("store_full set on a suppressed rectangle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("kept count beyond list depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("ready held right after accepting a beat");

   a_pipe_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff || cmp_status.busy) |-> (state_ff == S_SCAN))
      else $error("compare pipeline active outside the scan");

endmodule

/* bench/testbench.sv */
// Self-checking bench for the overlap suppression filter with an in-bench predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF    = 4;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int CELL_PITCH  = 64;
   localparam int PHASE_BEATS = 125;

   typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_kind_type;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_ready;
   osf_pkg::req_type                 req_data    = '0;
   logic                             rsp_valid;
   logic                             rsp_ready   = 1'b0;
   osf_pkg::rsp_type                 rsp_data;
   logic                             csr_wr_en   = 1'b0;
   logic [osf_pkg::CSR_IDX_BITS-1:0] csr_index   = osf_pkg::CSR_RATIO_NUM;
   logic [osf_pkg::RATIO_BITS-1:0]   csr_wr_data = '0;

   overlap_suppression_filter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // predictor state
   osf_pkg::rect_type              kept_list [osf_pkg::MAX_KEPT];
   int unsigned                    kept_total  = 0;
   logic [osf_pkg::AREA_BITS-1:0]  ref_area    = '0;
   logic [osf_pkg::RATIO_BITS-1:0] ratio_num_q = osf_pkg::RATIO_NUM_RESET;
   logic [osf_pkg::RATIO_BITS-1:0] ratio_den_q = osf_pkg::RATIO_DEN_RESET;

   osf_pkg::req_type rect_backlog[$];
   osf_pkg::rsp_type pending_verdicts[$];
   int unsigned      rects_queued  = 0;
   int unsigned      verdicts_seen = 0;
   int unsigned      error_count   = 0;
   int unsigned      cycle_count   = 0;

   int unsigned    gap_left   = 0;
   int unsigned    burst_left = 0;
   bit             drain_wait = 1'b0;
   stall_kind_type stall_mode = STALL_NONE;
   int unsigned    stall_left = 0;

   function automatic int unsigned span_overlap(int unsigned a0, int unsigned alen,
                                                int unsigned b0, int unsigned blen);
      int unsigned lo, hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = ((a0 + alen) < (b0 + blen)) ? (a0 + alen) : (b0 + blen);
      return (hi > lo) ? (hi - lo) : 0;
   endfunction

   function automatic bit overlaps_too_much(osf_pkg::rect_type fresh,
                                            osf_pkg::rect_type held);
      int unsigned     ox, oy;
      longint unsigned scaled_overlap, scaled_ref;
      ox = span_overlap(32'(fresh.rect_x), 32'(fresh.rect_width),
                        32'(held.rect_x), 32'(held.rect_width));
      oy = span_overlap(32'(fresh.rect_y), 32'(fresh.rect_height),
                        32'(held.rect_y), 32'(held.rect_height));
      if (ox > (fresh.rect_width >> 1) && oy > (fresh.rect_height >> 1)) return 1'b1;
      // ratio limit as cross products: overlap * den > num * reference
      scaled_overlap = 64'(ox) * 64'(oy) * 64'(ratio_den_q);
      scaled_ref     = 64'(ratio_num_q) * 64'(ref_area);
      return scaled_overlap > scaled_ref;
   endfunction

   function automatic osf_pkg::rsp_type judge_rect(osf_pkg::req_type item);
      osf_pkg::rect_type fresh;
      osf_pkg::rsp_type  verdict;
      bit                hit;
      fresh.rect_x      = item.rect_x;
      fresh.rect_y      = item.rect_y;
      fresh.rect_width  = item.rect_width;
      fresh.rect_height = item.rect_height;
      if (item.first_of_set) begin
         kept_total = 0;
         ref_area   = osf_pkg::AREA_BITS'(item.rect_width) *
                      osf_pkg::AREA_BITS'(item.rect_height);
      end
      hit = 1'b0;
      for (int unsigned i = 0; i < kept_total; i++) begin
         if (overlaps_too_much(fresh, kept_list[i])) begin
            hit = 1'b1;
            break;
         end
      end
      verdict.keep       = !hit;
      verdict.store_full = 1'b0;
      if (!hit) begin
         if (kept_total < osf_pkg::MAX_KEPT) begin
            kept_list[kept_total] = fresh;
            kept_total++;
         end else begin
            verdict.store_full = 1'b1;
         end
      end
      return verdict;
   endfunction

   task automatic log_failure(string note);
      error_count++;
      if (error_count <= 10) $display("ERROR @%0t: %s", $time, note);
   endtask

   // driver: bursts of beats with random gaps, sometimes holding off until drained
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            pending_verdicts.insert(pending_verdicts.size(), judge_rect(req_data));
         if (!req_valid || req_ready) begin
            if (drain_wait && pending_verdicts.size() == 0) drain_wait = 1'b0;
            if (gap_left == 0 && !drain_wait && rect_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= rect_backlog.pop_front();
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  case ($urandom_range(0, 9))
                     0, 1, 2: gap_left = 0;
                     3, 4, 5: gap_left = $urandom_range(1, 8);
                     6, 7, 8: gap_left = $urandom_range(9, 80);
                     default: gap_left = $urandom_range(81, 200);
                  endcase
                  if ($urandom_range(0, 39) == 0) drain_wait = 1'b1;
               end
            end else begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end
         end
      end
   end

   // result side stalls in a randomly chosen mode, redrawn when its random hold runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_kind_type'($urandom_range(0, 3));
         stall_left = $urandom_range(50, 600);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:  rsp_ready <= 1'b1;
         STALL_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
         STALL_HEAVY: rsp_ready <= ($urandom_range(0, 9) == 0);
         default:     rsp_ready <= (cycle_count[3:0] < 4'd11);
      endcase
   end

   always @(posedge clock) begin
      osf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            log_failure($sformatf("result beat with nothing expected: keep=%0b store_full=%0b",
                                  rsp_data.keep, rsp_data.store_full));
         end else begin
            want = pending_verdicts.pop_front();
            verdicts_seen++;
            if (rsp_data.keep !== want.keep || rsp_data.store_full !== want.store_full)
               log_failure($sformatf(
                  "expected keep=%0b store_full=%0b, got keep=%0b store_full=%0b",
                  want.keep, want.store_full, rsp_data.keep, rsp_data.store_full));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic queue_beat(osf_pkg::req_type item);
      rect_backlog.insert(rect_backlog.size(), item);
      rects_queued++;
   endtask

   task automatic queue_rect(int unsigned x, int unsigned y, int unsigned w, int unsigned h,
                             bit first);
      osf_pkg::req_type item;
      item.rect_x       = osf_pkg::COORD_BITS'(x);
      item.rect_y       = osf_pkg::COORD_BITS'(y);
      item.rect_width   = osf_pkg::COORD_BITS'(w);
      item.rect_height  = osf_pkg::COORD_BITS'(h);
      item.first_of_set = first;
      queue_beat(item);
   endtask

   function automatic logic [osf_pkg::COORD_BITS-1:0] pick_extent();
      case ($urandom_range(0, 9))
         7, 8:    return osf_pkg::COORD_BITS'($urandom_range(1, 1500));
         9:       return osf_pkg::COORD_BITS'($urandom_range(1, 4095));
         default: return osf_pkg::COORD_BITS'($urandom_range(1, 200));
      endcase
   endfunction

   function automatic int unsigned pick_set_size();
      case ($urandom_range(0, 9))
         0:       return 1;
         1, 2:    return $urandom_range(20, 40);
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   // one cluster: opening rectangle, then near copies, neighbors, strays and some noise that may open a new set
   task automatic queue_cluster(int unsigned count);
      osf_pkg::req_type members[$];
      osf_pkg::req_type item, base;
      int               spread;
      item.rect_x       = osf_pkg::COORD_BITS'($urandom_range(0, 4095));
      item.rect_y       = osf_pkg::COORD_BITS'($urandom_range(0, 4095));
      item.rect_width   = pick_extent();
      item.rect_height  = pick_extent();
      item.first_of_set = 1'b1;
      members.insert(members.size(), item);
      for (int unsigned k = 1; k < count; k++) begin
         base = members[$urandom_range(0, members.size() - 1)];
         item = base;
         item.first_of_set = 1'b0;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               spread = int'(base.rect_width) / 2 + 1;
               item.rect_x = osf_pkg::COORD_BITS'(
                  32'(base.rect_x) + $urandom_range(0, 2 * spread) - spread);
               spread = int'(base.rect_height) / 2 + 1;
               item.rect_y = osf_pkg::COORD_BITS'(
                  32'(base.rect_y) + $urandom_range(0, 2 * spread) - spread);
               item.rect_width  = osf_pkg::COORD_BITS'(
                  32'(base.rect_width) + $urandom_range(0, 8) - 4);
               item.rect_height = osf_pkg::COORD_BITS'(
                  32'(base.rect_height) + $urandom_range(0, 8) - 4);
            end
            4, 5, 6: begin
               item.rect_x      = osf_pkg::COORD_BITS'(
                  32'(members[0].rect_x) + $urandom_range(0, 400) - 200);
               item.rect_y      = osf_pkg::COORD_BITS'(
                  32'(members[0].rect_y) + $urandom_range(0, 400) - 200);
               item.rect_width  = pick_extent();
               item.rect_height = pick_extent();
            end
            7, 8: begin
               item.rect_x      = osf_pkg::COORD_BITS'($urandom_range(0, 4095));
               item.rect_y      = osf_pkg::COORD_BITS'($urandom_range(0, 4095));
               item.rect_width  = pick_extent();
               item.rect_height = pick_extent();
            end
            default: begin
               item.rect_x       = osf_pkg::COORD_BITS'($urandom_range(0, 4095));
               item.rect_y       = osf_pkg::COORD_BITS'($urandom_range(0, 4095));
               item.rect_width   = osf_pkg::COORD_BITS'($urandom_range(0, 4095));
               item.rect_height  = osf_pkg::COORD_BITS'($urandom_range(0, 4095));
               item.first_of_set = 1'($urandom_range(0, 1));
            end
         endcase
         members.insert(members.size(), item);
      end
      foreach (members[m]) queue_beat(members[m]);
   endtask

   // disjoint grid cells: all kept until the list fills, then store_full
   task automatic queue_grid(int unsigned count);
      osf_pkg::req_type members[$];
      osf_pkg::req_type item;
      for (int unsigned k = 0; k < count; k++) begin
         item.rect_x       = osf_pkg::COORD_BITS'(
            (k % CELL_PITCH) * CELL_PITCH + $urandom_range(0, 15));
         item.rect_y       = osf_pkg::COORD_BITS'(
            (k / CELL_PITCH) * CELL_PITCH + $urandom_range(0, 15));
         item.rect_width   = osf_pkg::COORD_BITS'($urandom_range(1, 48));
         item.rect_height  = osf_pkg::COORD_BITS'($urandom_range(1, 48));
         item.first_of_set = (k == 0);
         members.insert(members.size(), item);
         queue_beat(item);
      end
      // repeats of stored cells get suppressed, repeats of unstored ones are kept again
      for (int unsigned k = 0; k < 6; k++) begin
         item = members[$urandom_range(0, count - 1)];
         item.first_of_set = 1'b0;
         queue_beat(item);
      end
   endtask

   task automatic await_idle();
      while (verdicts_seen != rects_queued) @(posedge clock);
   endtask

   task automatic write_ratio(logic [osf_pkg::RATIO_BITS-1:0] num,
                              logic [osf_pkg::RATIO_BITS-1:0] den);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= osf_pkg::CSR_RATIO_NUM;
      csr_wr_data <= num;
      @(posedge clock);
      csr_index   <= osf_pkg::CSR_RATIO_DEN;
      csr_wr_data <= den;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ratio_num_q = num;
      ratio_den_q = den;
   endtask

   initial begin
      int unsigned start_count;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // no set started yet: reference area is zero
      queue_rect(0, 0, 10, 10, 1'b0);
      queue_rect(5, 5, 10, 10, 1'b0);
      queue_rect(100, 100, 100, 100, 1'b1);
      queue_rect(150, 150, 100, 100, 1'b0);
      queue_rect(110, 110, 20, 20, 1'b0);
      queue_rect(190, 100, 40, 20, 1'b0);
      queue_rect(200, 300, 50, 50, 1'b0);
      queue_rect(120, 180, 60, 60, 1'b0);
      // far corner, right edge past the coordinate range
      queue_rect(4095, 4095, 4095, 4095, 1'b1);
      queue_rect(0, 0, 4095, 4095, 1'b0);
      queue_rect(4094, 4094, 2, 2, 1'b0);
      queue_rect(2000, 2000, 1, 1, 1'b0);
      // zero-size rectangles, including a zero reference area
      queue_rect(10, 10, 0, 50, 1'b1);
      queue_rect(10, 10, 20, 20, 1'b0);
      queue_rect(15, 15, 0, 5, 1'b0);
      queue_rect(12, 12, 3, 3, 1'b0);
      queue_rect(500, 500, 60, 0, 1'b1);
      queue_rect(500, 500, 60, 60, 1'b0);
      queue_rect(4095, 0, 1, 4095, 1'b1);
      queue_rect(12'hAAA, 12'h555, 12'h555, 12'hAAA, 1'b0);
      queue_rect(12'h555, 12'hAAA, 12'hAAA, 12'h555, 1'b1);
      queue_rect(12'h555, 12'hAAA, 12'hAAA, 12'h555, 1'b0);
      await_idle();

      for (int setting_idx = 0; setting_idx < 8; setting_idx++) begin
         case (setting_idx)
            0:       write_ratio(8'd0, 8'd1);
            1:       write_ratio(8'd255, 8'd1);
            2:       write_ratio(8'd1, 8'd255);
            3:       write_ratio(8'd255, 8'd255);
            4:       write_ratio(8'd7, 8'd0);      // ratio test disabled
            5:       write_ratio(osf_pkg::RATIO_NUM_RESET, osf_pkg::RATIO_DEN_RESET);
            default: write_ratio(osf_pkg::RATIO_BITS'($urandom_range(0, 255)),
                                 osf_pkg::RATIO_BITS'($urandom_range(1, 255)));
         endcase
         start_count = rects_queued;
         if (setting_idx == 1 || setting_idx == 5)
            queue_grid(osf_pkg::MAX_KEPT + $urandom_range(2, 8));
         while (rects_queued - start_count < PHASE_BEATS) queue_cluster(pick_set_size());
         await_idle();
      end

      repeat (osf_pkg::MAX_KEPT + 16) @(posedge clock);
      if (pending_verdicts.size() != 0)
         log_failure($sformatf("%0d results never arrived", pending_verdicts.size()));
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
